[design/bcd_pkg.sv]
`default_nettype none

package bcd_pkg;

  // configuration register map, one word per register at 4*index
  localparam int unsigned AddrW = 5;
  localparam int unsigned IdxW  = 3;

  localparam logic [IdxW-1:0] RegLevelOffset  = 3'd0;
  localparam logic [IdxW-1:0] RegTargetSpeed  = 3'd1;
  localparam logic [IdxW-1:0] RegAngleGain    = 3'd2;
  localparam logic [IdxW-1:0] RegRateGain     = 3'd3;
  localparam logic [IdxW-1:0] RegSpeedGain    = 3'd4;
  localparam logic [IdxW-1:0] RegIntegralGain = 3'd5;
  localparam logic [IdxW-1:0] RegTurnGain     = 3'd6;

  // gains carry 16 fraction bits
  localparam int unsigned QFrac = 16;
  localparam int unsigned SumW  = 45;
  localparam int unsigned DrvW  = 29;

  localparam logic signed [15:0]      TipLimit      = 16'sd8000;
  localparam logic signed [17:0]      IntegralLimit = 18'sd10000;
  localparam logic signed [DrvW-1:0]  LeftLimit     = 29'sd66;
  localparam logic signed [DrvW-1:0]  RightLimit    = 29'sd64;
  localparam logic signed [SumW-1:0]  QRound        = SumW'((1 << QFrac) - 1);

  // x / 5 == (x * RecipFive) >> RecipShift for x below 699050
  localparam logic [18:0]  RecipFive  = 19'd419431;
  localparam int unsigned  RecipShift = 21;

  typedef struct packed {
    logic signed [15:0] level_offset;
    logic signed [15:0] target_speed;
    logic signed [23:0] angle_gain;
    logic signed [23:0] rate_gain;
    logic signed [23:0] speed_gain;
    logic signed [23:0] integral_gain;
    logic signed [23:0] turn_gain;
  } cfg_t;

  localparam cfg_t CfgReset = '{
    level_offset:  -16'sd500,
    target_speed:  16'sd0,
    angle_gain:    24'sd4129,
    rate_gain:     -24'sd708,
    speed_gain:    24'sd58982,
    integral_gain: 24'sd590,
    turn_gain:     24'sd23593
  };

  typedef struct packed {
    logic signed [15:0] roll_angle;
    logic signed [15:0] roll_rate;
    logic signed [15:0] left_speed;
    logic signed [15:0] right_speed;
    logic signed [7:0]  turn_command;
    logic               run_flag;
  } in_word_t;

  typedef struct packed {
    logic signed [16:0] angle_err;
    logic signed [15:0] roll_rate;
    logic signed [17:0] filt_err;
    logic signed [18:0] err_sum;
    logic signed [7:0]  turn_command;
    logic               tipped;
  } loop_word_t;

  typedef struct packed {
    logic signed [40:0] p_angle;
    logic signed [39:0] p_rate;
    logic signed [41:0] p_speed;
    logic signed [42:0] p_integ;
    logic signed [31:0] p_turn;
    logic               tipped;
  } prod_word_t;

endpackage

`default_nettype wire

[design/balance_cascade_drive_unit.sv]
// path: an accepted word passes the input, speed-loop, product, sum and drive registers in turn
// throughput: one word per cycle while the output is not stalled, set by the filter and integral update
// a stalled output holds its word while the upstream stages keep filling
// reset: clears all stage valids, the speed filter and integral state, and loads
// every configuration register with its default
`default_nettype none

module balance_cascade_drive_unit (
  input  wire          clk_i,
  input  wire          rst_ni,
  // slave stream
  input  wire          s_axis_tvalid,
  output logic         s_axis_tready,
  // roll_angle[15:0] roll_rate[31:16] left_speed[47:32] right_speed[63:48]
  // turn_command[71:64]
  input  wire  [71:0]  s_axis_tdata,
  // run_flag[0]
  input  wire          s_axis_tuser,
  // master stream
  output logic         m_axis_tvalid,
  input  wire          m_axis_tready,
  // left_drive[7:0] right_drive[15:8]
  output logic [15:0]  m_axis_tdata,
  // tipped_over[0]
  output logic         m_axis_tuser,
  // configuration port
  input  wire          psel,
  input  wire          penable,
  input  wire          pwrite,
  input  wire  [4:0]   paddr,
  input  wire  [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);

  bcd_pkg::cfg_t        cfg;
  logic                 in_valid_q;
  bcd_pkg::in_word_t    in_word_q, in_word_d;
  logic                 loop_ready;
  logic                 loop_valid;
  bcd_pkg::loop_word_t  loop_word;
  logic                 prod_ready;
  logic                 prod_valid;
  bcd_pkg::prod_word_t  prod_word;
  logic                 drv_ready;
  logic signed [7:0]    left_drive;
  logic signed [7:0]    right_drive;
  logic                 tipped_over;

  assign s_axis_tready = !in_valid_q || loop_ready;

  always_comb begin
    in_word_d.roll_angle   = s_axis_tdata[15:0];
    in_word_d.roll_rate    = s_axis_tdata[31:16];
    in_word_d.left_speed   = s_axis_tdata[47:32];
    in_word_d.right_speed  = s_axis_tdata[63:48];
    in_word_d.turn_command = s_axis_tdata[71:64];
    in_word_d.run_flag     = s_axis_tuser;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_word_q <= in_word_d;
    end
  end

  bcd_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  bcd_speed_loop u_loop (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .in_valid_i  (in_valid_q),
    .in_word_i   (in_word_q),
    .in_ready_o  (loop_ready),
    .out_valid_o (loop_valid),
    .out_word_o  (loop_word),
    .out_ready_i (prod_ready)
  );

  bcd_products u_prod (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .in_valid_i  (loop_valid),
    .in_word_i   (loop_word),
    .in_ready_o  (prod_ready),
    .out_valid_o (prod_valid),
    .out_word_o  (prod_word),
    .out_ready_i (drv_ready)
  );

  bcd_drive_out u_drv (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (prod_valid),
    .in_word_i     (prod_word),
    .in_ready_o    (drv_ready),
    .out_valid_o   (m_axis_tvalid),
    .left_drive_o  (left_drive),
    .right_drive_o (right_drive),
    .tipped_o      (tipped_over),
    .out_ready_i   (m_axis_tready)
  );

  assign m_axis_tdata = {right_drive, left_drive};
  assign m_axis_tuser = tipped_over;

endmodule

`default_nettype wire

[design/bcd_cfg_regs.sv]
`default_nettype none

module bcd_cfg_regs (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire                          psel,
  input  wire                          penable,
  input  wire                          pwrite,
  input  wire  [bcd_pkg::AddrW-1:0]    paddr,
  input  wire  [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready,
  output bcd_pkg::cfg_t                cfg_o
);

  bcd_pkg::cfg_t                 cfg_q;
  logic                          wr_en;
  logic [bcd_pkg::IdxW-1:0]      reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite;
  assign reg_idx = paddr[bcd_pkg::AddrW-1:2];
  assign cfg_o   = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= bcd_pkg::CfgReset;
    end else if (wr_en) begin
      case (reg_idx)
        bcd_pkg::RegLevelOffset:  cfg_q.level_offset  <= pwdata[15:0];
        bcd_pkg::RegTargetSpeed:  cfg_q.target_speed  <= pwdata[15:0];
        bcd_pkg::RegAngleGain:    cfg_q.angle_gain    <= pwdata[23:0];
        bcd_pkg::RegRateGain:     cfg_q.rate_gain     <= pwdata[23:0];
        bcd_pkg::RegSpeedGain:    cfg_q.speed_gain    <= pwdata[23:0];
        bcd_pkg::RegIntegralGain: cfg_q.integral_gain <= pwdata[23:0];
        bcd_pkg::RegTurnGain:     cfg_q.turn_gain     <= pwdata[23:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      bcd_pkg::RegLevelOffset:  prdata = 32'(cfg_q.level_offset);
      bcd_pkg::RegTargetSpeed:  prdata = 32'(cfg_q.target_speed);
      bcd_pkg::RegAngleGain:    prdata = 32'(cfg_q.angle_gain);
      bcd_pkg::RegRateGain:     prdata = 32'(cfg_q.rate_gain);
      bcd_pkg::RegSpeedGain:    prdata = 32'(cfg_q.speed_gain);
      bcd_pkg::RegIntegralGain: prdata = 32'(cfg_q.integral_gain);
      bcd_pkg::RegTurnGain:     prdata = 32'(cfg_q.turn_gain);
      default:                  prdata = 32'd0;
    endcase
  end

endmodule

`default_nettype wire

[design/bcd_speed_loop.sv]
`default_nettype none

module bcd_speed_loop (
  input  wire                       clk_i,
  input  wire                       rst_ni,
  input  wire  bcd_pkg::cfg_t       cfg_i,
  input  wire                       in_valid_i,
  input  wire  bcd_pkg::in_word_t   in_word_i,
  output logic                      in_ready_o,
  output logic                      out_valid_o,
  output bcd_pkg::loop_word_t       out_word_o,
  input  wire                       out_ready_i
);

  logic signed [17:0] filt_q, filt_d;
  logic signed [17:0] sum_q, sum_d;
  logic               out_valid_q;
  bcd_pkg::loop_word_t out_word_q, out_word_d;

  logic signed [17:0] speed_err;
  logic signed [20:0] mix;
  logic               mix_neg;
  logic [19:0]        mix_mag;
  logic [38:0]        quo_prod;
  logic [17:0]        quo;
  logic signed [18:0] sum_new;
  logic signed [18:0] sum_run;
  logic signed [17:0] sum_clamped;
  logic               tipped;
  logic               fire;

  assign in_ready_o  = !out_valid_q || out_ready_i;
  assign fire        = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

  always_comb begin
    speed_err = 18'(in_word_i.left_speed) + 18'(in_word_i.right_speed)
              - 18'(cfg_i.target_speed);
    // (4*old + new) / 5, truncated toward zero, on the magnitude
    mix      = (21'(filt_q) <<< 2) + 21'(speed_err);
    mix_neg  = mix[20];
    mix_mag  = mix_neg ? 20'(-mix) : 20'(mix);
    quo_prod = 39'(mix_mag) * 39'(bcd_pkg::RecipFive);
    quo      = quo_prod[bcd_pkg::RecipShift +: 18];
    filt_d   = mix_neg ? $signed(~quo + 18'd1) : $signed(quo);

    sum_new = 19'(sum_q) + 19'(filt_d);
    sum_run = in_word_i.run_flag ? sum_new : 19'sd0;

    if (sum_run > 19'(bcd_pkg::IntegralLimit)) begin
      sum_clamped = bcd_pkg::IntegralLimit;
    end else if (sum_run < -19'(bcd_pkg::IntegralLimit)) begin
      sum_clamped = -bcd_pkg::IntegralLimit;
    end else begin
      sum_clamped = sum_run[17:0];
    end

    tipped = (in_word_i.roll_angle >= bcd_pkg::TipLimit)
          || (in_word_i.roll_angle <= -bcd_pkg::TipLimit);
    sum_d  = tipped ? 18'sd0 : sum_clamped;

    out_word_d.angle_err    = 17'(cfg_i.level_offset) - 17'(in_word_i.roll_angle);
    out_word_d.roll_rate    = in_word_i.roll_rate;
    out_word_d.filt_err     = filt_d;
    out_word_d.err_sum      = sum_run;
    out_word_d.turn_command = in_word_i.turn_command;
    out_word_d.tipped       = tipped;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      filt_q      <= '0;
      sum_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (fire) begin
        filt_q <= filt_d;
        sum_q  <= sum_d;
      end
      if (in_ready_o) begin
        out_valid_q <= in_valid_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      out_word_q <= out_word_d;
    end
  end

  a_sum_bounded : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (sum_q <= bcd_pkg::IntegralLimit) && (sum_q >= -bcd_pkg::IntegralLimit))
    else $error("speed error sum out of bounds");

  a_tip_clears_sum : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && tipped) |=> (sum_q == 18'sd0))
    else $error("speed error sum not cleared on tip");

endmodule

`default_nettype wire

[design/bcd_products.sv]
`default_nettype none

module bcd_products (
  input  wire                         clk_i,
  input  wire                         rst_ni,
  input  wire  bcd_pkg::cfg_t         cfg_i,
  input  wire                         in_valid_i,
  input  wire  bcd_pkg::loop_word_t   in_word_i,
  output logic                        in_ready_o,
  output logic                        out_valid_o,
  output bcd_pkg::prod_word_t         out_word_o,
  input  wire                         out_ready_i
);

  logic                 out_valid_q;
  bcd_pkg::prod_word_t  out_word_q, out_word_d;
  logic                 load;

  assign in_ready_o  = !out_valid_q || out_ready_i;
  assign load        = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

  always_comb begin
    out_word_d.p_angle = 41'(cfg_i.angle_gain)    * 41'(in_word_i.angle_err);
    out_word_d.p_rate  = 40'(cfg_i.rate_gain)     * 40'(in_word_i.roll_rate);
    out_word_d.p_speed = 42'(cfg_i.speed_gain)    * 42'(in_word_i.filt_err);
    out_word_d.p_integ = 43'(cfg_i.integral_gain) * 43'(in_word_i.err_sum);
    out_word_d.p_turn  = 32'(cfg_i.turn_gain)     * 32'(in_word_i.turn_command);
    out_word_d.tipped  = in_word_i.tipped;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      out_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_word_q <= out_word_d;
    end
  end

endmodule

`default_nettype wire

[design/bcd_drive_out.sv]
`default_nettype none

module bcd_drive_out (
  input  wire                         clk_i,
  input  wire                         rst_ni,
  input  wire                         in_valid_i,
  input  wire  bcd_pkg::prod_word_t   in_word_i,
  output logic                        in_ready_o,
  output logic                        out_valid_o,
  output logic signed [7:0]           left_drive_o,
  output logic signed [7:0]           right_drive_o,
  output logic                        tipped_o,
  input  wire                         out_ready_i
);

  // shift down by the fraction bits, rounding toward zero
  function automatic logic signed [bcd_pkg::DrvW-1:0] trunc_q16(
    input logic signed [bcd_pkg::SumW-1:0] v
  );
    logic signed [bcd_pkg::SumW-1:0] biased;
    biased = v[bcd_pkg::SumW-1] ? v + bcd_pkg::QRound : v;
    return bcd_pkg::DrvW'(biased >>> bcd_pkg::QFrac);
  endfunction

  logic                               sum_valid_q;
  logic signed [bcd_pkg::SumW-1:0]    left_sum_q, left_sum_d;
  logic signed [bcd_pkg::SumW-1:0]    right_sum_q, right_sum_d;
  logic                               sum_tipped_q;
  logic signed [bcd_pkg::SumW-1:0]    base;
  logic                               sum_ready;
  logic                               sum_load;

  logic                               out_valid_q;
  logic signed [7:0]                  left_q, left_d;
  logic signed [7:0]                  right_q, right_d;
  logic                               tipped_q;
  logic signed [bcd_pkg::DrvW-1:0]    left_t, right_t;
  logic                               out_ready;
  logic                               out_load;

  assign out_ready  = !out_valid_q || out_ready_i;
  assign out_load   = sum_valid_q && out_ready;
  assign sum_ready  = !sum_valid_q || out_ready;
  assign sum_load   = in_valid_i && sum_ready;
  assign in_ready_o = sum_ready;

  assign out_valid_o   = out_valid_q;
  assign left_drive_o  = left_q;
  assign right_drive_o = right_q;
  assign tipped_o      = tipped_q;

  always_comb begin
    base = bcd_pkg::SumW'(in_word_i.p_angle) + bcd_pkg::SumW'(in_word_i.p_rate)
         + bcd_pkg::SumW'(in_word_i.p_speed) + bcd_pkg::SumW'(in_word_i.p_integ);
    left_sum_d  = base + bcd_pkg::SumW'(in_word_i.p_turn);
    right_sum_d = base - bcd_pkg::SumW'(in_word_i.p_turn);
  end

  always_comb begin
    left_t  = trunc_q16(left_sum_q);
    right_t = trunc_q16(right_sum_q);

    if (left_t > bcd_pkg::LeftLimit) begin
      left_d = 8'(bcd_pkg::LeftLimit);
    end else if (left_t < -bcd_pkg::LeftLimit) begin
      left_d = 8'(-bcd_pkg::LeftLimit);
    end else begin
      left_d = 8'(left_t);
    end

    if (right_t > bcd_pkg::RightLimit) begin
      right_d = 8'(bcd_pkg::RightLimit);
    end else if (right_t < -bcd_pkg::RightLimit) begin
      right_d = 8'(-bcd_pkg::RightLimit);
    end else begin
      right_d = 8'(right_t);
    end

    if (sum_tipped_q) begin
      left_d  = 8'sd0;
      right_d = 8'sd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (sum_ready) begin
        sum_valid_q <= in_valid_i;
      end
      if (out_ready) begin
        out_valid_q <= sum_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (sum_load) begin
      left_sum_q   <= left_sum_d;
      right_sum_q  <= right_sum_d;
      sum_tipped_q <= in_word_i.tipped;
    end
    if (out_load) begin
      left_q   <= left_d;
      right_q  <= right_d;
      tipped_q <= sum_tipped_q;
    end
  end

  a_tip_zero_drive : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && tipped_q) |-> (left_q == 8'sd0 && right_q == 8'sd0))
    else $error("drive not zero while tipped");

  a_drive_bounded : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (left_q <= 8'sd66 && left_q >= -8'sd66
                     && right_q <= 8'sd64 && right_q >= -8'sd64))
    else $error("drive outside limits");

endmodule

`default_nettype wire

[bench/bcd_checker.sv]
module bcd_checker
  import bcd_pkg::*;
(
  input  wire             clk_i,
  input  wire             rst_ni,
  input  wire             s_tvalid_i,
  input  wire             s_tready_i,
  input  wire [71:0]      s_tdata_i,
  input  wire             s_tuser_i,
  input  wire             m_tvalid_i,
  input  wire             m_tready_i,
  input  wire [15:0]      m_tdata_i,
  input  wire             m_tuser_i,
  input  wire             psel_i,
  input  wire             penable_i,
  input  wire             pwrite_i,
  input  wire [AddrW-1:0] paddr_i,
  input  wire [31:0]      pwdata_i,
  input  wire [31:0]      prdata_i,
  input  wire             pready_i,
  input  wire             end_check_i,
  output int              mismatches_o,
  output int              pending_o,
  output int              ticks_o,
  output int              drives_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint TiltTrip   = 8000;
  localparam longint SumClamp   = 10000;
  localparam longint LeftClamp  = 66;
  localparam longint RightClamp = 64;
  localparam int     PrintCap   = 60;

  typedef struct packed {
    logic signed [7:0] left;
    logic signed [7:0] right;
    logic              tipped;
  } drive_word_t;

  cfg_t        settings_q;
  longint      filt_err_q;
  longint      err_sum_q;
  drive_word_t drive_expect_q[$];
  int          mismatches;
  int          ticks;
  int          drives;
  bit          end_seen;

  function automatic longint q16_trunc(input longint v);
    if (v < 0) return -((-v) >>> QFrac);
    return v >>> QFrac;
  endfunction

  function automatic longint clamp_to(input longint v, input longint lim);
    if (v > lim) return lim;
    if (v < -lim) return -lim;
    return v;
  endfunction

  // advances the speed filter and integral, returns the drive for this tick
  function automatic drive_word_t predict_drive(input in_word_t w);
    longint      angle;
    longint      err;
    longint      base;
    longint      tprod;
    longint      left;
    longint      right;
    logic        tipped;
    drive_word_t d;
    angle  = longint'($signed(w.roll_angle));
    tipped = (angle >= TiltTrip) || (angle <= -TiltTrip);
    err = longint'($signed(w.left_speed)) + longint'($signed(w.right_speed))
        - longint'($signed(settings_q.target_speed));
    filt_err_q = (4 * filt_err_q + err) / 5;
    err_sum_q += filt_err_q;
    if (!w.run_flag) err_sum_q = 0;
    base = longint'($signed(settings_q.angle_gain))
           * (longint'($signed(settings_q.level_offset)) - angle)
         + longint'($signed(settings_q.rate_gain)) * longint'($signed(w.roll_rate))
         + longint'($signed(settings_q.speed_gain)) * filt_err_q
         + longint'($signed(settings_q.integral_gain)) * err_sum_q;
    tprod = longint'($signed(settings_q.turn_gain)) * longint'($signed(w.turn_command));
    left  = clamp_to(q16_trunc(base + tprod), LeftClamp);
    right = clamp_to(q16_trunc(base - tprod), RightClamp);
    // integral is clamped only after the drive has used it
    err_sum_q = clamp_to(err_sum_q, SumClamp);
    if (tipped) begin
      err_sum_q = 0;
      left      = 0;
      right     = 0;
    end
    d.left   = left[7:0];
    d.right  = right[7:0];
    d.tipped = tipped;
    return d;
  endfunction

  task automatic report_mismatch(input string what);
    if (mismatches < PrintCap) $display("%0t  mismatch: %s", $realtime, what);
    mismatches++;
  endtask

  task automatic apply_write(input logic [IdxW-1:0] idx, input logic [31:0] data);
    case (idx)
      RegLevelOffset:  settings_q.level_offset  = data[15:0];
      RegTargetSpeed:  settings_q.target_speed  = data[15:0];
      RegAngleGain:    settings_q.angle_gain    = data[23:0];
      RegRateGain:     settings_q.rate_gain     = data[23:0];
      RegSpeedGain:    settings_q.speed_gain    = data[23:0];
      RegIntegralGain: settings_q.integral_gain = data[23:0];
      RegTurnGain:     settings_q.turn_gain     = data[23:0];
      default: ;
    endcase
  endtask

  task automatic check_read(input logic [IdxW-1:0] idx, input logic [31:0] data);
    logic [31:0] want;
    logic [31:0] mask;
    want = '0;
    mask = '0;
    case (idx)
      RegLevelOffset:  begin want = 32'(settings_q.level_offset);  mask = 32'hffff;   end
      RegTargetSpeed:  begin want = 32'(settings_q.target_speed);  mask = 32'hffff;   end
      RegAngleGain:    begin want = 32'(settings_q.angle_gain);    mask = 32'hffffff; end
      RegRateGain:     begin want = 32'(settings_q.rate_gain);     mask = 32'hffffff; end
      RegSpeedGain:    begin want = 32'(settings_q.speed_gain);    mask = 32'hffffff; end
      RegIntegralGain: begin want = 32'(settings_q.integral_gain); mask = 32'hffffff; end
      RegTurnGain:     begin want = 32'(settings_q.turn_gain);     mask = 32'hffffff; end
      default: ;
    endcase
    if ((data & mask) != (want & mask))
      report_mismatch($sformatf("register %0d reads %h, expected %h",
                                idx, data & mask, want & mask));
  endtask

  task automatic check_drive(input drive_word_t got);
    drive_word_t want;
    if (drive_expect_q.size() == 0) begin
      report_mismatch($sformatf("drive word %0d arrived with none expected", drives));
    end else begin
      want = drive_expect_q.pop_front();
      if (got !== want)
        report_mismatch($sformatf(
          "drive word %0d: left %0d/%0d right %0d/%0d tipped %0b/%0b (got/expected)",
          drives, got.left, want.left, got.right, want.right, got.tipped, want.tipped));
    end
    drives++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    in_word_t    tick;
    drive_word_t got;
    if (!rst_ni) begin
      settings_q = CfgReset;
      filt_err_q = 0;
      err_sum_q  = 0;
      drive_expect_q.delete();
    end else begin
      if (psel_i && penable_i && pready_i) begin
        if (pwrite_i) apply_write(paddr_i[AddrW-1:2], pwdata_i);
        else check_read(paddr_i[AddrW-1:2], prdata_i);
      end
      // retire first, so a word can never match a tick accepted at the same edge
      if (m_tvalid_i && m_tready_i) begin
        got.left   = m_tdata_i[7:0];
        got.right  = m_tdata_i[15:8];
        got.tipped = m_tuser_i;
        check_drive(got);
      end
      if (s_tvalid_i && s_tready_i) begin
        tick.roll_angle   = s_tdata_i[15:0];
        tick.roll_rate    = s_tdata_i[31:16];
        tick.left_speed   = s_tdata_i[47:32];
        tick.right_speed  = s_tdata_i[63:48];
        tick.turn_command = s_tdata_i[71:64];
        tick.run_flag     = s_tuser_i;
        drive_expect_q.push_back(predict_drive(tick));
        ticks++;
      end
      if (end_check_i && !end_seen) begin
        end_seen = 1'b1;
        if (drive_expect_q.size() != 0)
          report_mismatch($sformatf("%0d expected drive words never came",
                                    drive_expect_q.size()));
      end
    end
    mismatches_o <= mismatches;
    pending_o    <= drive_expect_q.size();
    ticks_o      <= ticks;
    drives_o     <= drives;
  end

endmodule

[bench/tb.sv]
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import bcd_pkg::*;

  localparam int StallLimit  = 1000;
  localparam int Phases      = 8;
  localparam int FirstRandom = 200;
  localparam int PhaseTicks  = 247;
  localparam int TailCycles  = 8;
  // no register behind this index, writes must be ignored
  localparam logic [IdxW-1:0] RegSpare = 3'd7;

  logic             clk      = 1'b0;
  logic             rst_n    = 1'b0;
  logic             s_tvalid = 1'b0;
  wire              s_tready;
  logic [71:0]      s_tdata  = '0;
  logic             s_tuser  = 1'b0;
  wire              m_tvalid;
  logic             m_tready = 1'b0;
  wire  [15:0]      m_tdata;
  wire              m_tuser;
  logic             psel     = 1'b0;
  logic             penable  = 1'b0;
  logic             pwrite   = 1'b0;
  logic [AddrW-1:0] paddr    = '0;
  logic [31:0]      pwdata   = '0;
  wire  [31:0]      prdata;
  wire              pready;
  logic             end_check = 1'b0;
  int               mismatches;
  int               pending;
  int               ticks;
  int               drives;
  bit               calm = 1'b0;
  int               level_now = -500;

  always #5ns clk = ~clk;

  balance_cascade_drive_unit dut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .s_axis_tvalid (s_tvalid),
    .s_axis_tready (s_tready),
    .s_axis_tdata  (s_tdata),
    .s_axis_tuser  (s_tuser),
    .m_axis_tvalid (m_tvalid),
    .m_axis_tready (m_tready),
    .m_axis_tdata  (m_tdata),
    .m_axis_tuser  (m_tuser),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  bcd_checker drive_check (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .s_tvalid_i   (s_tvalid),
    .s_tready_i   (s_tready),
    .s_tdata_i    (s_tdata),
    .s_tuser_i    (s_tuser),
    .m_tvalid_i   (m_tvalid),
    .m_tready_i   (m_tready),
    .m_tdata_i    (m_tdata),
    .m_tuser_i    (m_tuser),
    .psel_i       (psel),
    .penable_i    (penable),
    .pwrite_i     (pwrite),
    .paddr_i      (paddr),
    .pwdata_i     (pwdata),
    .prdata_i     (prdata),
    .pready_i     (pready),
    .end_check_i  (end_check),
    .mismatches_o (mismatches),
    .pending_o    (pending),
    .ticks_o      (ticks),
    .drives_o     (drives)
  );

  function automatic int span(input int lo, input int hi);
    return lo + int'($urandom_range(32'(hi - lo), 0));
  endfunction

  function automatic in_word_t mk_tick(input int angle, input int rate, input int lspd,
                                       input int rspd, input int turn, input bit run);
    in_word_t w;
    w.roll_angle   = 16'(angle);
    w.roll_rate    = 16'(rate);
    w.left_speed   = 16'(lspd);
    w.right_speed  = 16'(rspd);
    w.turn_command = 8'(turn);
    w.run_flag     = run;
    return w;
  endfunction

  // mostly near balance so the drive stays off its clamps, some near the tip limit, the rest full scale
  function automatic in_word_t random_tick();
    int kind;
    int angle;
    bit run;
    kind = $urandom_range(0, 15);
    run  = ($urandom_range(0, 15) != 0) && (kind != 15);
    if (kind >= 10 && kind <= 12)
      return mk_tick(span(-18000, 18000), span(-32768, 32767), span(-32768, 32767),
                     span(-32768, 32767), span(-128, 127), run);
    if (kind == 13) begin
      angle = span(7990, 8010);
      if ($urandom_range(0, 1)) angle = -angle;
    end else begin
      angle = level_now + span(-400, 400);
    end
    if (angle > 18000) angle = 18000;
    if (angle < -18000) angle = -18000;
    return mk_tick(angle, span(-3000, 3000), span(-40, 40), span(-40, 40),
                   span(-128, 127), run);
  endfunction

  function automatic logic [23:0] random_gain(input int nominal);
    int n;
    n = (nominal < 0) ? -nominal : nominal;
    if ($urandom_range(0, 4) == 0) return 24'(span(-8388608, 8388607));
    return 24'(span(-2 * n, 2 * n));
  endfunction

  function automatic cfg_t random_settings();
    cfg_t c;
    c.level_offset  = ($urandom_range(0, 3) == 0) ? 16'(span(-18000, 18000))
                                                  : 16'(span(-1500, 1500));
    c.target_speed  = ($urandom_range(0, 3) == 0) ? 16'(span(-32768, 32767))
                                                  : 16'(span(-60, 60));
    c.angle_gain    = random_gain(4129);
    c.rate_gain     = random_gain(-708);
    c.speed_gain    = random_gain(58982);
    c.integral_gain = random_gain(590);
    c.turn_gain     = random_gain(23593);
    return c;
  endfunction

  task automatic send_tick(input in_word_t w);
    if (!calm && $urandom_range(0, 5) == 0) begin
      s_tvalid <= 1'b0;
      repeat (span(1, 16)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {w.turn_command, w.right_speed, w.left_speed, w.roll_rate, w.roll_angle};
    s_tuser  <= w.run_flag;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  task automatic apb_access(input bit wr, input logic [IdxW-1:0] idx,
                            input logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic read_settings();
    for (int i = RegLevelOffset; i <= RegTurnGain; i++)
      apb_access(1'b0, IdxW'(i), '0);
  endtask

  task automatic load_settings(input cfg_t c);
    apb_access(1'b1, RegLevelOffset,  32'(c.level_offset));
    apb_access(1'b1, RegTargetSpeed,  32'(c.target_speed));
    apb_access(1'b1, RegAngleGain,    32'(c.angle_gain));
    apb_access(1'b1, RegRateGain,     32'(c.rate_gain));
    apb_access(1'b1, RegSpeedGain,    32'(c.speed_gain));
    apb_access(1'b1, RegIntegralGain, 32'(c.integral_gain));
    apb_access(1'b1, RegTurnGain,     32'(c.turn_gain));
    level_now = int'(c.level_offset);
    read_settings();
  endtask

  // the checker's count is registered, so wait for a clock edge before looking at it
  task automatic drain();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (TailCycles) @(posedge clk);
  endtask

  initial begin : sink
    int n;
    forever begin
      if (!calm && $urandom_range(0, 3) == 0) begin
        m_tready <= 1'b0;
        n = span(1, 16);
        repeat (n) @(posedge clk);
      end
      m_tready <= 1'b1;
      n = span(1, 24);
      repeat (n) @(posedge clk);
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < StallLimit) begin
      @(posedge clk);
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || psel) quiet = 0;
      else quiet++;
    end
    $display("watchdog: %0d cycles without a handshake", quiet);
    $display("end of test: mismatches");
    $finish;
  end

  initial begin : stimulus
    cfg_t setting;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    read_settings();

    // directed ticks on the reset settings
    send_tick(mk_tick(0, 0, 0, 0, 0, 1'b1));
    send_tick(mk_tick(-500, 0, 0, 0, 0, 1'b1));
    send_tick(mk_tick(18000, 0, 0, 0, 0, 1'b1));
    send_tick(mk_tick(-18000, 0, 0, 0, 0, 1'b1));
    send_tick(mk_tick(8000, 0, 0, 0, 0, 1'b1));
    send_tick(mk_tick(7999, 0, 0, 0, 0, 1'b1));
    send_tick(mk_tick(-8000, 0, 0, 0, 0, 1'b1));
    send_tick(mk_tick(-7999, 0, 0, 0, 0, 1'b1));
    send_tick(mk_tick(-500, 32767, 0, 0, 0, 1'b1));
    send_tick(mk_tick(-500, -32768, 0, 0, 0, 1'b1));
    send_tick(mk_tick(-500, 0, 0, 0, 127, 1'b1));
    send_tick(mk_tick(-500, 0, 0, 0, -128, 1'b1));
    // integral runs into its clamp, then swings the other way
    repeat (4) send_tick(mk_tick(-500, 0, 32767, 32767, 0, 1'b1));
    repeat (3) send_tick(mk_tick(-500, 0, -32768, -32768, 0, 1'b1));
    send_tick(mk_tick(-500, 0, 20, 20, 5, 1'b0));
    send_tick(mk_tick(-500, 0, 32767, 32767, 0, 1'b1));
    send_tick(mk_tick(9000, 0, 32767, 32767, 0, 1'b1));
    send_tick(mk_tick(-500, -32768, 32767, 32767, 127, 1'b1));
    repeat (FirstRandom) send_tick(random_tick());

    for (int p = 1; p < Phases; p++) begin
      drain();
      case (p)
        1: setting = '{level_offset: 16'sd18000, target_speed: 16'sd32767,
                       angle_gain: 24'sd8388607, rate_gain: 24'sd8388607,
                       speed_gain: 24'sd8388607, integral_gain: 24'sd8388607,
                       turn_gain: 24'sd8388607};
        2: setting = '{level_offset: -16'sd18000, target_speed: -16'sd32768,
                       angle_gain: 24'h800000, rate_gain: 24'h800000,
                       speed_gain: 24'h800000, integral_gain: 24'h800000,
                       turn_gain: 24'h800000};
        default: setting = random_settings();
      endcase
      if (p == 3) apb_access(1'b1, RegSpare, $urandom());
      load_settings(setting);
      if (p == Phases - 1) calm = 1'b1;
      repeat (PhaseTicks) send_tick(random_tick());
    end

    drain();
    end_check <= 1'b1;
    repeat (2) @(posedge clk);
    $display("covered %0d control ticks and %0d drive words over %0d register settings,",
             ticks, drives, Phases);
    $display("with tip-over edges, integral clear and clamp, and full-scale gains");
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
